// ----- src/nrcc_pkg.sv -----
package nrcc_pkg;

    // Fixed widths of the beats and the configuration port.
    localparam int FIELD_W   = 20;
    localparam int SLOT_W    = 20;
    localparam int NUM_CH    = 3;
    localparam int NUM_REFS  = 5;
    localparam int CFG_W     = NUM_CH * SLOT_W;
    localparam int CFG_IDX_W = 3;
    localparam int CLASS_W   = 3;

    // Defaults handed to the top level.
    localparam int PERIOD_WIDTH_DEF   = 20;
    localparam int STABLE_REPEATS_DEF = 2;

    // Queue between the distance pipeline and the run filter.
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = QUEUE_AW + 1;

    // Number of register stages in the distance pipeline.
    localparam int FRONT_STAGES = 5;

    typedef enum logic [CLASS_W-1:0] {
        CLS_RED     = 3'd0,
        CLS_GREEN   = 3'd1,
        CLS_BLUE    = 3'd2,
        CLS_WHITE   = 3'd3,
        CLS_BLACK   = 3'd4,
        CLS_UNKNOWN = 3'd5
    } t_class;

    typedef struct packed {
        logic   vld;
        t_class cls;
    } t_cls_beat;

endpackage

// ----- src/nrcc_if.sv -----
interface nrcc_rd_if;
    logic                        valid;
    logic                        ready;
    logic [nrcc_pkg::FIELD_W-1:0] red_period;
    logic [nrcc_pkg::FIELD_W-1:0] green_period;
    logic [nrcc_pkg::FIELD_W-1:0] blue_period;

    modport source (output valid, output red_period, output green_period,
                    output blue_period, input ready);
    modport sink   (input valid, input red_period, input green_period,
                    input blue_period, output ready);
endinterface

interface nrcc_res_if;
    logic                         valid;
    logic                         ready;
    logic [nrcc_pkg::CLASS_W-1:0] color_class;

    modport source (output valid, output color_class, input ready);
    modport sink   (input valid, input color_class, output ready);
endinterface

// ----- src/nrcc_front.sv -----
module nrcc_front #(
    parameter int PERIOD_WIDTH = nrcc_pkg::PERIOD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [nrcc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [nrcc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_acc,
    input  logic [nrcc_pkg::FIELD_W-1:0]   i_red,
    input  logic [nrcc_pkg::FIELD_W-1:0]   i_green,
    input  logic [nrcc_pkg::FIELD_W-1:0]   i_blue,
    output nrcc_pkg::t_cls_beat            o_push
);
    import nrcc_pkg::*;

    localparam int W  = PERIOD_WIDTH;
    localparam int SW = 2 * W;
    localparam int DW = 2 * W + 2;

    logic [W-1:0]  r_ref  [NUM_REFS][NUM_CH];
    logic [W-1:0]  r_dif  [NUM_REFS][NUM_CH];
    logic [SW-1:0] r_sq   [NUM_REFS][NUM_CH];
    logic [DW-1:0] r_dist [NUM_REFS];
    logic [DW-1:0] r_a_d, r_b_d, r_c_d;
    t_class        r_a_c, r_b_c;
    t_class        r_cls;
    logic [FRONT_STAGES-1:0] r_vld;

    logic [W-1:0] w_in [NUM_CH];
    logic         w_b_lt_a, w_c_lt_a, w_c_lt_b;
    t_class       n_cls;

    assign w_in[0] = i_red[W-1:0];
    assign w_in[1] = i_green[W-1:0];
    assign w_in[2] = i_blue[W-1:0];

    // Reference registers keep only the low PERIOD_WIDTH bits of each slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REFS; i++) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_ref[i][c] <= '0;
                end
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < NUM_REFS; i++) begin
                if (i_cfg_idx == CFG_IDX_W'(i)) begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        r_ref[i][c] <= i_cfg_data[c*SLOT_W +: W];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_acc};
        end
    end

    always_comb begin
        w_b_lt_a = r_b_d < r_a_d;
        w_c_lt_a = r_c_d < r_a_d;
        w_c_lt_b = r_c_d < r_b_d;
        if (w_b_lt_a) begin
            n_cls = w_c_lt_b ? CLS_BLACK : r_b_c;
        end else begin
            n_cls = w_c_lt_a ? CLS_BLACK : r_a_c;
        end
    end

    // Distance pipeline: difference, square, sum, pairwise compare, final pick.
    // Strict compares keep the earlier class on equal distances.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_REFS; i++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_dif[i][c] <= (w_in[c] >= r_ref[i][c]) ? (w_in[c] - r_ref[i][c])
                                                        : (r_ref[i][c] - w_in[c]);
                r_sq[i][c]  <= r_dif[i][c] * r_dif[i][c];
            end
            r_dist[i] <= DW'(r_sq[i][0]) + DW'(r_sq[i][1]) + DW'(r_sq[i][2]);
        end
        r_a_d <= (r_dist[1] < r_dist[0]) ? r_dist[1] : r_dist[0];
        r_a_c <= (r_dist[1] < r_dist[0]) ? CLS_GREEN : CLS_RED;
        r_b_d <= (r_dist[3] < r_dist[2]) ? r_dist[3] : r_dist[2];
        r_b_c <= (r_dist[3] < r_dist[2]) ? CLS_WHITE : CLS_BLUE;
        r_c_d <= r_dist[4];
        r_cls <= n_cls;
    end

    assign o_push.vld = r_vld[FRONT_STAGES-1];
    assign o_push.cls = r_cls;

endmodule

// ----- src/nrcc_queue.sv -----
module nrcc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    output logic                o_room,
    input  nrcc_pkg::t_cls_beat i_push,
    input  logic                i_pop,
    output nrcc_pkg::t_cls_beat o_head
);
    import nrcc_pkg::*;

    t_class              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [CNT_W-1:0]    r_cnt, r_credit;
    logic                w_pop;

    // A credit is held from the moment a beat enters the pipeline until it
    // leaves the queue, so the queue can never overflow.
    assign o_room      = r_credit < CNT_W'(QUEUE_DEPTH);
    assign w_pop       = i_pop && (r_cnt != '0);
    assign o_head.vld  = r_cnt != '0;
    assign o_head.cls  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_mem[r_wp] <= i_push.cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_cnt    <= '0;
            r_credit <= '0;
        end else begin
            if (i_push.vld) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt    <= r_cnt + CNT_W'(i_push.vld) - CNT_W'(w_pop);
            r_credit <= r_credit + CNT_W'(i_take) - CNT_W'(w_pop);
        end
    end

    a_cnt_within_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_credit)
        else $error("queue holds more beats than credits issued");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld |-> (r_cnt != CNT_W'(QUEUE_DEPTH)) || w_pop)
        else $error("queue written while full");

endmodule

// ----- src/nrcc_back.sv -----
module nrcc_back #(
    parameter int STABLE_REPEATS = nrcc_pkg::STABLE_REPEATS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nrcc_pkg::t_cls_beat i_head,
    output logic                o_pop,
    nrcc_res_if.source          o_res
);
    import nrcc_pkg::*;

    localparam logic [1:0] REP_MAX = 2'(STABLE_REPEATS);

    t_class     r_prev, n_prev;
    logic [1:0] r_cnt, n_cnt;
    logic       r_ovld;
    t_class     r_color, n_color;

    assign o_pop = i_head.vld && (!r_ovld || o_res.ready);

    always_comb begin
        if (i_head.cls == r_prev) begin
            n_prev = r_prev;
            n_cnt  = (r_cnt < REP_MAX) ? r_cnt + 2'd1 : r_cnt;
        end else begin
            n_prev = i_head.cls;
            n_cnt  = 2'd0;
        end
        n_color = (n_cnt >= REP_MAX) ? i_head.cls : CLS_UNKNOWN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= CLS_UNKNOWN;
            r_cnt  <= 2'd0;
            r_ovld <= 1'b0;
        end else if (o_pop) begin
            r_prev  <= n_prev;
            r_cnt   <= n_cnt;
            r_ovld  <= 1'b1;
            r_color <= n_color;
        end else if (o_res.ready) begin
            r_ovld <= 1'b0;
        end
    end

    assign o_res.valid       = r_ovld;
    assign o_res.color_class = r_color;

    // A reported class is always the one the filter is currently tracking.
    a_class_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_color != CLS_UNKNOWN) |-> r_color == r_prev)
        else $error("reported class differs from the tracked class");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= REP_MAX))
        else $error("repeat count beyond its saturation point");

endmodule

// ----- src/nearest_reference_color_classifier.sv -----
// A reading's class passes the pipeline registers, the queue and the output register.
// Throughput: one reading per cycle while credits last, via the five-stage distance
// pipeline; an eight-entry queue with credits lets it run while the output stalls.
// Reset clears the reference registers to zero, empties pipeline and queue,
// and sets the run filter to unknown with a zero repeat count.
module nearest_reference_color_classifier #(
    parameter int PERIOD_WIDTH   = nrcc_pkg::PERIOD_WIDTH_DEF,
    parameter int STABLE_REPEATS = nrcc_pkg::STABLE_REPEATS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [nrcc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [nrcc_pkg::CFG_W-1:0]     i_cfg_data,
    nrcc_rd_if.sink                        i_rd,
    nrcc_res_if.source                     o_res
);
    import nrcc_pkg::*;

    logic      w_room, w_acc, w_pop;
    t_cls_beat w_push, w_head;

    assign i_rd.ready = w_room;
    assign w_acc      = i_rd.valid && w_room;

    nrcc_front #(
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (w_acc),
        .i_red      (i_rd.red_period),
        .i_green    (i_rd.green_period),
        .i_blue     (i_rd.blue_period),
        .o_push     (w_push)
    );

    nrcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_acc),
        .o_room  (w_room),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    nrcc_back #(
        .STABLE_REPEATS (STABLE_REPEATS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule
